// ===== rtl/wspr_message_encoder_unit_macros.svh =====
// ----------------------------------------------------------------------------
// WSPR message encoder assertion macros
// Shared concurrent assertion helpers. They compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef WSPR_MESSAGE_ENCODER_UNIT_MACROS_SVH
`define WSPR_MESSAGE_ENCODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define WME_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wme: same-cycle check failed");
// Next-cycle implication.
`define WME_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wme: next-cycle check failed");
`else
`define WME_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WME_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/wme_pkg.sv =====
// ----------------------------------------------------------------------------
// WSPR message encoder package
// Constants, command and status types, and small decode functions shared
// by the controller and the datapath.
// ----------------------------------------------------------------------------
package wme_pkg;

    // Message and code geometry.
    localparam int unsigned SYM_COUNT   = 162;
    localparam int unsigned SYM_ADDR_W  = $clog2(SYM_COUNT);
    localparam int unsigned MSG_BITS    = 50;
    localparam int unsigned CALL_BITS   = 28;
    localparam int unsigned LOC_BITS    = 15;
    localparam int unsigned CODE_STEPS  = 81;
    localparam int unsigned PACK_STEPS  = 5;

    // Convolutional code taps.
    localparam logic [31:0] POLY_A = 32'hF2D0_5351;
    localparam logic [31:0] POLY_B = 32'hE461_3C47;

    // Power handling.
    localparam int unsigned POWER_MAX   = 1000000;
    localparam int unsigned NORM_LIMIT  = 100000;
    localparam int unsigned RND_LIMIT_0 = 150000;
    localparam int unsigned RND_LIMIT_3 = 350000;
    localparam int unsigned RND_LIMIT_7 = 750000;
    localparam int unsigned DBM_START   = 50;
    localparam int unsigned PWR_OFFSET  = 64;

    // Locator packing.
    localparam int unsigned LOC_BASE    = 179;
    localparam int unsigned LOC_MULT    = 180;

    // Controller to datapath commands.
    typedef struct packed {
        logic       capture;
        logic       init;
        logic       pack_step;
        logic [2:0] pack_idx;
        logic       finish;
        logic       code_step;
        logic       intlv_step;
        logic       rd_issue;
        logic       out_load;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic is_read;
        logic enc_valid;
    } t_dp_status;

    // Decoded character.
    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_char_val;

    // Map an ASCII byte to the message alphabet.
    function automatic t_char_val char_value(logic [7:0] c);
        t_char_val r;
        r.ok  = 1'b1;
        r.val = '0;
        if (c == 8'h20) begin
            r.val = 6'd36;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.val = 6'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            r.val = 6'(c - 8'd55);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r.val = 6'(c - 8'd87);
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    // 8-bit bit reversal for the interleaver.
    function automatic logic [7:0] reverse8(logic [7:0] v);
        logic [7:0] r;
        for (int b = 0; b < 8; b++) begin
            r[b] = v[7-b];
        end
        return r;
    endfunction

    // Sync vector bit at a symbol position below SYM_COUNT.
    function automatic logic sync_bit(logic [7:0] pos);
        logic [7:0] sync_byte;
        unique case (pos[7:3])
            5'd0:    sync_byte = 8'd3;
            5'd1:    sync_byte = 8'd113;
            5'd2:    sync_byte = 8'd164;
            5'd3:    sync_byte = 8'd7;
            5'd4:    sync_byte = 8'd164;
            5'd5:    sync_byte = 8'd64;
            5'd6:    sync_byte = 8'd179;
            5'd7:    sync_byte = 8'd88;
            5'd8:    sync_byte = 8'd88;
            5'd9:    sync_byte = 8'd149;
            5'd10:   sync_byte = 8'd52;
            5'd11:   sync_byte = 8'd86;
            5'd12:   sync_byte = 8'd4;
            5'd13:   sync_byte = 8'd201;
            5'd14:   sync_byte = 8'd205;
            5'd15:   sync_byte = 8'd226;
            5'd16:   sync_byte = 8'd160;
            5'd17:   sync_byte = 8'd12;
            5'd18:   sync_byte = 8'd88;
            5'd19:   sync_byte = 8'd99;
            default: sync_byte = 8'd0;
        endcase
        return sync_byte[pos[2:0]];
    endfunction

endpackage

// ===== rtl/wme_in_if.sv =====
// ----------------------------------------------------------------------------
// WSPR message encoder request channel
// Valid/ready channel carrying one encode or read request.
// ----------------------------------------------------------------------------
interface wme_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [47:0] call_chars;
    logic [31:0] locator_chars;
    logic [23:0] power_mw;
    logic [7:0]  symbol_position;

    modport source (
        output valid, req_type, call_chars, locator_chars, power_mw, symbol_position,
        input  ready
    );
    modport sink (
        input  valid, req_type, call_chars, locator_chars, power_mw, symbol_position,
        output ready
    );
endinterface

// ===== rtl/wme_out_if.sv =====
// ----------------------------------------------------------------------------
// WSPR message encoder response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface wme_out_if;
    logic       valid;
    logic       ready;
    logic       encode_ok;
    logic [1:0] symbol_value;

    modport source (
        output valid, encode_ok, symbol_value,
        input  ready
    );
    modport sink (
        input  valid, encode_ok, symbol_value,
        output ready
    );
endinterface

// ===== rtl/wme_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module wme_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 162
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/wme_datapath.sv =====
// ----------------------------------------------------------------------------
// WSPR message encoder datapath
// Request registers, character checks, message packing, convolutional
// coder, interleave address generation, symbol store and result registers.
// ----------------------------------------------------------------------------
module wme_datapath import wme_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic        i_req_type,
    input  logic [47:0] i_call_chars,
    input  logic [31:0] i_locator_chars,
    input  logic [23:0] i_power_mw,
    input  logic [7:0]  i_symbol_position,
    output t_dp_status  o_status,
    output logic        o_encode_ok,
    output logic [1:0]  o_symbol_value
);

    // Captured request.
    logic                  r_req_type;
    logic [47:0]           r_call;
    logic [31:0]           r_loc;
    logic [23:0]           r_power;
    logic [7:0]            r_pos;

    // Packing and coding state.
    logic [19:0]           r_p;
    logic [5:0]            r_d;
    logic [CALL_BITS-1:0]  r_acc;
    logic [LOC_BITS-1:0]   r_t;
    logic [MSG_BITS-1:0]   r_msg;
    logic [31:0]           r_sh;
    logic [SYM_COUNT-1:0]  r_coded;
    logic [7:0]            r_i;
    logic                  r_written;
    logic                  r_encode_ok;
    logic [1:0]            r_symbol_value;

    t_char_val             cv [6];
    t_char_val             lv [4];
    logic                  chars_ok;
    logic                  enc_valid;
    logic [5:0]            call_mult;
    logic [CALL_BITS-1:0]  call_add;
    logic [CALL_BITS-1:0]  call_next;
    logic                  p_small;
    logic [19:0]           p_x10;
    logic [LOC_BITS-1:0]   t_init;
    logic [LOC_BITS-1:0]   t_step;
    logic [5:0]            rnd;
    logic [5:0]            pdbm;
    logic [21:0]           m1;
    logic [31:0]           sh_in;
    logic                  par_a;
    logic                  par_b;
    logic [7:0]            i_plus1;
    logic [7:0]            i_next;
    logic                  pos_in_range;
    logic                  ram_rd;
    logic [1:0]            sym_value;

    // Character decode of the captured callsign and locator.
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            cv[k] = char_value(r_call[8*k +: 8]);
        end
        for (int k = 0; k < 4; k++) begin
            lv[k] = char_value(r_loc[8*k +: 8]);
        end
    end

    // Encode request validity.
    assign chars_ok = cv[0].ok && cv[1].ok && cv[2].ok && cv[3].ok && cv[4].ok && cv[5].ok
                   && lv[0].ok && lv[1].ok && lv[2].ok && lv[3].ok;
    assign enc_valid = chars_ok
                    && (cv[2].val <= 6'd9) && (lv[2].val <= 6'd9) && (lv[3].val <= 6'd9)
                    && (lv[0].val >= 6'd10) && (lv[0].val <= 6'd35)
                    && (lv[1].val >= 6'd10) && (lv[1].val <= 6'd35)
                    && (r_power != 24'd0) && (r_power <= 24'(POWER_MAX));

    assign o_status.is_read   = r_req_type;
    assign o_status.enc_valid = enc_valid;

    // Callsign packing: one multiply-accumulate per step.
    always_comb begin
        case (i_cmd.pack_idx)
            3'd0: begin
                call_mult = 6'd36;
                call_add  = CALL_BITS'(cv[1].val);
            end
            3'd1: begin
                call_mult = 6'd10;
                call_add  = CALL_BITS'(cv[2].val);
            end
            3'd2: begin
                call_mult = 6'd27;
                call_add  = CALL_BITS'(cv[3].val) - CALL_BITS'(10);
            end
            3'd3: begin
                call_mult = 6'd27;
                call_add  = CALL_BITS'(cv[4].val) - CALL_BITS'(10);
            end
            default: begin
                call_mult = 6'd27;
                call_add  = CALL_BITS'(cv[5].val) - CALL_BITS'(10);
            end
        endcase
    end
    assign call_next = CALL_BITS'(r_acc * CALL_BITS'(call_mult)) + call_add;

    // Power normalization: scale by ten while below the decade limit.
    assign p_small = r_p < 20'(NORM_LIMIT);
    assign p_x10   = (r_p << 3) + (r_p << 1);

    // Locator packing in two steps.
    assign t_init = LOC_BITS'(LOC_BASE)
                  - LOC_BITS'(LOC_BITS'(10) * (LOC_BITS'(lv[0].val) - LOC_BITS'(10)))
                  - LOC_BITS'(lv[2].val);
    assign t_step = LOC_BITS'(r_t * LOC_BITS'(LOC_MULT))
                  + LOC_BITS'(LOC_BITS'(10) * (LOC_BITS'(lv[1].val) - LOC_BITS'(10)))
                  + LOC_BITS'(lv[3].val);

    // Power rounding to a dBm value ending in 0, 3 or 7.
    always_comb begin
        if (r_p <= 20'(RND_LIMIT_0)) begin
            rnd = 6'd0;
        end else if (r_p <= 20'(RND_LIMIT_3)) begin
            rnd = 6'd3;
        end else if (r_p <= 20'(RND_LIMIT_7)) begin
            rnd = 6'd7;
        end else begin
            rnd = 6'd10;
        end
    end
    assign pdbm = r_d + rnd;
    assign m1   = {r_t, 7'b000_0000} + 22'(pdbm) + 22'(PWR_OFFSET);

    // Convolutional coder: message enters most significant bit first.
    assign sh_in = r_sh | 32'(r_msg[MSG_BITS-1]);
    assign par_a = ^(sh_in & POLY_A);
    assign par_b = ^(sh_in & POLY_B);

    // Interleave index: skip the bit-reversed positions past the store.
    assign i_plus1 = r_i + 8'd1;
    assign i_next  = (reverse8(i_plus1) < 8'(SYM_COUNT)) ? i_plus1 : r_i + 8'd2;

    // Read result assembly.
    assign pos_in_range = r_pos < 8'(SYM_COUNT);
    assign sym_value    = (r_req_type && r_written && pos_in_range)
                        ? {ram_rd, sync_bit(r_pos)} : 2'b00;

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type <= i_req_type;
            r_call     <= i_call_chars;
            r_loc      <= i_locator_chars;
            r_power    <= i_power_mw;
            r_pos      <= i_symbol_position;
        end
        if (i_cmd.init) begin
            r_p   <= r_power[19:0];
            r_d   <= 6'(DBM_START);
            r_acc <= CALL_BITS'(cv[0].val);
            r_t   <= t_init;
        end
        if (i_cmd.pack_step) begin
            r_acc <= call_next;
            if (p_small) begin
                r_p <= p_x10;
                r_d <= r_d - 6'd10;
            end
            if (i_cmd.pack_idx == 3'd0) begin
                r_t <= t_step;
            end
        end
        if (i_cmd.finish) begin
            r_msg <= {r_acc, m1};
            r_sh  <= '0;
            r_i   <= '0;
        end
        if (i_cmd.code_step) begin
            r_sh    <= sh_in << 1;
            r_msg   <= r_msg << 1;
            r_coded <= {r_coded[SYM_COUNT-3:0], par_a, par_b};
        end
        if (i_cmd.intlv_step) begin
            r_coded <= r_coded << 1;
            r_i     <= i_next;
        end
        if (i_cmd.out_load) begin
            r_encode_ok    <= !r_req_type && enc_valid;
            r_symbol_value <= sym_value;
        end
    end

    // The store reads as zero until the first successful encode.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= 1'b0;
        end else if (i_cmd.intlv_step) begin
            r_written <= 1'b1;
        end
    end

    // Data half of the channel symbols; the sync half is a constant.
    wme_ram #(
        .WIDTH (1),
        .DEPTH (SYM_COUNT)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.intlv_step),
        .i_wr_addr (SYM_ADDR_W'(reverse8(r_i))),
        .i_wr_data (r_coded[SYM_COUNT-1]),
        .i_rd_en   (i_cmd.rd_issue && pos_in_range),
        .i_rd_addr (SYM_ADDR_W'(r_pos)),
        .o_rd_data (ram_rd)
    );

    assign o_encode_ok    = r_encode_ok;
    assign o_symbol_value = r_symbol_value;

endmodule

// ===== rtl/wme_controller.sv =====
// ----------------------------------------------------------------------------
// WSPR message encoder controller
// Sequences the check, pack, code and interleave phases and owns the
// request and response handshakes.
// ----------------------------------------------------------------------------
`include "wspr_message_encoder_unit_macros.svh"

module wme_controller import wme_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_PACK   = 3'd2;
    localparam logic [2:0] S_FINISH = 3'd3;
    localparam logic [2:0] S_CODE   = 3'd4;
    localparam logic [2:0] S_INTLV  = 3'd5;
    localparam logic [2:0] S_RESULT = 3'd6;

    localparam logic [7:0] PACK_LAST = 8'(PACK_STEPS - 1);
    localparam logic [7:0] CODE_LAST = 8'(CODE_STEPS - 1);
    localparam logic [7:0] SYM_LAST  = 8'(SYM_COUNT - 1);

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [7:0] r_count;
    logic [7:0] n_count;
    logic       r_out_valid;
    logic       n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and command decode.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.is_read) begin
                    o_cmd.rd_issue = 1'b1;
                    n_state        = S_RESULT;
                end else begin
                    o_cmd.init = 1'b1;
                    n_count    = '0;
                    n_state    = i_status.enc_valid ? S_PACK : S_RESULT;
                end
            end
            S_PACK: begin
                o_cmd.pack_step = 1'b1;
                o_cmd.pack_idx  = r_count[2:0];
                if (r_count == PACK_LAST) begin
                    n_state = S_FINISH;
                end else begin
                    n_count = r_count + 8'd1;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_count      = '0;
                n_state      = S_CODE;
            end
            S_CODE: begin
                o_cmd.code_step = 1'b1;
                if (r_count == CODE_LAST) begin
                    n_count = '0;
                    n_state = S_INTLV;
                end else begin
                    n_count = r_count + 8'd1;
                end
            end
            S_INTLV: begin
                o_cmd.intlv_step = 1'b1;
                if (r_count == SYM_LAST) begin
                    n_state = S_RESULT;
                end else begin
                    n_count = r_count + 8'd1;
                end
            end
            S_RESULT: begin
                // Wait until the previous result has left the output register.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // A request transaction always leads into the check cycle.
    `WME_ASSERT_NXT(a_accept_check, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_CHECK)
    // Interleave writes stay inside the symbol store.
    `WME_ASSERT_IMP(a_intlv_range, i_clk, i_rst_n, o_cmd.intlv_step, r_count < 8'(SYM_COUNT))
    // A loaded result is presented on the next cycle.
    `WME_ASSERT_NXT(a_load_shows, i_clk, i_rst_n, o_cmd.out_load, r_out_valid)
    // A pending result is never dropped while the sink stalls.
    `WME_ASSERT_NXT(a_hold_result, i_clk, i_rst_n, r_out_valid && !i_out_ready, r_out_valid)

endmodule

// ===== rtl/wspr_message_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// WSPR message encoder unit
// Type 1 message encoder with a 162-symbol channel symbol store.
//
//   Channel  Dir  Transaction
//   i_req    in   encode (callsign, locator, power) or read (symbol position)
//   o_rsp    out  encode_ok for encodes, symbol_value for reads
//
// A valid encode goes from its transaction to its result through the check
// state, five packing steps, the finish state, 81 coder steps and
// 162 interleave writes through the single write port of the symbol store.
// An invalid encode and a read go from the check state straight to the result.
// Reset is synchronous; the store reads as zero until the first valid encode,
// so no clearing pass is needed after reset.
// A result waits in the output register while the next request is taken;
// the unit holds its final step only while an older result is still pending.
// ----------------------------------------------------------------------------
module wspr_message_encoder_unit import wme_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    wme_in_if.sink    i_req,
    wme_out_if.source o_rsp
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequencing and handshakes.
    wme_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Encoding, storage and result payload.
    wme_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_req_type        (i_req.req_type),
        .i_call_chars      (i_req.call_chars),
        .i_locator_chars   (i_req.locator_chars),
        .i_power_mw        (i_req.power_mw),
        .i_symbol_position (i_req.symbol_position),
        .o_status          (status),
        .o_encode_ok       (o_rsp.encode_ok),
        .o_symbol_value    (o_rsp.symbol_value)
    );

endmodule
